// File: hw/rtl/ukfq_pkg.sv
// ----------------------------------------------------------------------------
// ukfq_pkg
// Shared types for the unique-key FIFO queue: status codes, operation codes,
// controller states, memory control and the result item.
// ----------------------------------------------------------------------------
package ukfq_pkg;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DEQ
    } t_state;

    typedef struct packed {
        logic re;
        logic we;
    } t_mem_ctl;

    typedef struct packed {
        t_status     status;
        logic [31:0] key;
        logic [31:0] value;
        logic [4:0]  occupancy;
        logic        is_empty;
    } t_result;

endpackage

// File: hw/rtl/unique_key_fifo_queue_top.sv
// ----------------------------------------------------------------------------
// unique_key_fifo_queue_top
// FIFO queue of key/value pairs that rejects an enqueue whose key is held.
// ----------------------------------------------------------------------------
// One item at a time. An enqueue reads every held key from the single-port
// ring memory, one per cycle, before its result is registered, and stops
// early when a duplicate is found; a full ring is scanned and then refused.
// A dequeue reads the head entry and then registers it, or registers the
// empty status without a read. A result waits while the output is stalled.
// The next item is taken the cycle after a result is registered, even if that
// result has not yet been picked up. Storage needs no clearing after reset.
module unique_key_fifo_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic signed [31:0] i_in_key,
    input  logic signed [31:0] i_in_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_out_key,
    output logic signed [31:0] o_out_value,
    output logic [4:0]         o_occupancy,
    output logic               o_is_empty
);
    import ukfq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_mem_ctl      mem_ctl;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wkey;
    logic [31:0]   mem_wval;
    logic [31:0]   mem_rkey;
    logic [31:0]   mem_rval;
    t_result       result;

    ukfq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (i_op),
        .i_key      ($unsigned(i_in_key)),
        .i_value    ($unsigned(i_in_value)),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (result),
        .o_mem_ctl  (mem_ctl),
        .o_mem_addr (mem_addr),
        .o_mem_wkey (mem_wkey),
        .o_mem_wval (mem_wval),
        .i_mem_rkey (mem_rkey),
        .i_mem_rval (mem_rval)
    );

    ukfq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_ctl  (mem_ctl),
        .i_addr (mem_addr),
        .i_wkey (mem_wkey),
        .i_wval (mem_wval),
        .o_rkey (mem_rkey),
        .o_rval (mem_rval)
    );

    assign o_status    = result.status;
    assign o_out_key   = $signed(result.key);
    assign o_out_value = $signed(result.value);
    assign o_occupancy = result.occupancy;
    assign o_is_empty  = result.is_empty;

endmodule

// File: hw/rtl/ukfq_mem.sv
// ----------------------------------------------------------------------------
// ukfq_mem
// Single-port key/value ring storage, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module ukfq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  ukfq_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]      i_addr,
    input  logic [31:0]        i_wkey,
    input  logic [31:0]        i_wval,
    output logic [31:0]        o_rkey,
    output logic [31:0]        o_rval
);
    import ukfq_pkg::*;

    logic [31:0] r_key_mem [DEPTH];
    logic [31:0] r_val_mem [DEPTH];
    logic [31:0] r_rkey;
    logic [31:0] r_rval;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_key_mem[i_addr] <= i_wkey;
            r_val_mem[i_addr] <= i_wval;
        end
        if (i_ctl.re) begin
            r_rkey <= r_key_mem[i_addr];
            r_rval <= r_val_mem[i_addr];
        end
    end

    assign o_rkey = r_rkey;
    assign o_rval = r_rval;

endmodule

// File: hw/rtl/ukfq_ctrl.sv
// ----------------------------------------------------------------------------
// ukfq_ctrl
// Sequencer for the queue: ring pointers, entry count, duplicate-key scan,
// append and head removal, and the result register.
// ----------------------------------------------------------------------------
module ukfq_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic [31:0]        i_key,
    input  logic [31:0]        i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output ukfq_pkg::t_result  o_result,
    output ukfq_pkg::t_mem_ctl o_mem_ctl,
    output logic [AW-1:0]      o_mem_addr,
    output logic [31:0]        o_mem_wkey,
    output logic [31:0]        o_mem_wval,
    input  logic [31:0]        i_mem_rkey,
    input  logic [31:0]        i_mem_rval
);
    import ukfq_pkg::*;

    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_state        r_state, n_state;
    logic [31:0]   r_key, n_key;
    logic [31:0]   r_val, n_val;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_left, n_left;
    logic          r_rd_pend, n_rd_pend;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    logic          out_free;
    logic          hit;
    logic          load_out;
    logic [CW+4:0] occ_wide;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] pos);
        return (pos == LAST_POS) ? '0 : pos + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_val  <= n_val;
        r_ptr  <= n_ptr;
        r_left <= n_left;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_val       = r_val;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_rd_pend   = r_rd_pend;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_mem_ctl   = '0;
        o_mem_addr  = r_ptr;
        load_out    = 1'b0;

        out_free = !r_out_valid || !i_stall;
        hit      = r_rd_pend && (i_mem_rkey == r_key);
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key     = i_key;
                    n_val     = i_value;
                    n_ptr     = r_head;
                    n_left    = r_count;
                    n_rd_pend = 1'b0;
                    n_state   = (i_op == OP_DEQ) ? S_DEQ : S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit || r_left == '0) begin
                    if (out_free) begin
                        load_out     = 1'b1;
                        n_out.key    = '0;
                        n_out.value  = '0;
                        n_rd_pend    = 1'b0;
                        n_state      = S_IDLE;
                        if (hit) begin
                            n_out.status = ST_DUP;
                        end else if (r_count == FULL_CNT) begin
                            n_out.status = ST_FULL;
                        end else begin
                            o_mem_ctl.we = 1'b1;
                            o_mem_addr   = r_tail;
                            n_tail       = ring_next(r_tail);
                            n_count      = r_count + 1'b1;
                            n_out.status = ST_OK;
                        end
                    end
                end else begin
                    o_mem_ctl.re = 1'b1;
                    o_mem_addr   = r_ptr;
                    n_ptr        = ring_next(r_ptr);
                    n_left       = r_left - 1'b1;
                    n_rd_pend    = 1'b1;
                end
            end
            S_DEQ: begin
                if (r_count == '0) begin
                    if (out_free) begin
                        load_out     = 1'b1;
                        n_out.status = ST_EMPTY;
                        n_out.key    = '0;
                        n_out.value  = '0;
                        n_state      = S_IDLE;
                    end
                end else if (!r_rd_pend) begin
                    o_mem_ctl.re = 1'b1;
                    o_mem_addr   = r_head;
                    n_rd_pend    = 1'b1;
                end else if (out_free) begin
                    load_out     = 1'b1;
                    n_out.status = ST_OK;
                    n_out.key    = i_mem_rkey;
                    n_out.value  = i_mem_rval;
                    n_head       = ring_next(r_head);
                    n_count      = r_count - 1'b1;
                    n_rd_pend    = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        occ_wide = {5'b0, n_count};
        if (load_out) begin
            n_out_valid     = 1'b1;
            n_out.occupancy = occ_wide[4:0];
            n_out.is_empty  = (n_count == '0);
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;
    assign o_mem_wkey = r_key;
    assign o_mem_wval = r_val;

endmodule
